>>> rtl/core/ffpa_pkg.sv
// ffpa_pkg: shared types, widths and codes for the first-fit page allocator
// used by ffpa_ctrl, ffpa_dpath, first_fit_page_allocator and ffpa_checker
// no dependencies
package ffpa_pkg;

  // table geometry
  localparam int PAGE_ENTRIES = 65536;
  localparam int ADDR_SPAN    = 65536;
  localparam int PAGE_LIMIT   = (PAGE_ENTRIES < ADDR_SPAN) ? PAGE_ENTRIES : ADDR_SPAN;
  localparam int PAGE_AW      = $clog2(PAGE_LIMIT);
  localparam int MAX_RUN      = 32;

  // field widths
  localparam int PAGE_W  = 16;
  localparam int COUNT_W = 6;
  localparam int FRAME_W = 20;
  localparam int KIND_W  = 2;
  localparam int LIM_W   = 17;
  localparam int SUM_W   = LIM_W + 1;
  localparam int ENTRY_W = FRAME_W + 1;
  localparam int CFG_IW  = 1;

  // register reset values
  localparam logic [LIM_W-1:0] SEARCH_FIRST_RST = LIM_W'(4608);
  localparam logic [LIM_W-1:0] SEARCH_END_RST   = LIM_W'(65536);

  // register indexes
  localparam logic [CFG_IW-1:0] REG_SEARCH_FIRST = 1'b0;
  localparam logic [CFG_IW-1:0] REG_SEARCH_END   = 1'b1;

  // request operations
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_MAP   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_UNMAP = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DONE  = 2'd2;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK,
    ST_S_TEST,
    ST_S_EVAL,
    ST_MAP,
    ST_F_READ,
    ST_F_EMIT,
    ST_DONE_OK,
    ST_DONE_FAIL
  } ffpa_state_t;

  // controller to datapath
  typedef struct packed {
    logic load_req;
    logic clr_step;
    logic rd_issue;
    logic srch_adv;
    logic srch_skip;
    logic idx_clear;
    logic emit_map;
    logic emit_unmap;
    logic emit_done_ok;
    logic emit_done_fail;
  } ffpa_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;
    logic out_free;
    logic op_free;
    logic is_search;
    logic count_zero;
    logic count_bad;
    logic range_bad;
    logic idx_end;
    logic idx_last;
    logic start_ok;
    logic page_beyond;
    logic page_taken;
  } ffpa_stat_t;

endpackage

>>> rtl/core/ffpa_ctrl.sv
// ffpa_ctrl: sequencer for clearing, search, map and free walks
// depends on ffpa_pkg
module ffpa_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  ffpa_pkg::ffpa_stat_t stat,
  output ffpa_pkg::ffpa_cmd_t  cmd
);

  ffpa_pkg::ffpa_state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ffpa_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = (state != ffpa_pkg::ST_IDLE);
    unique case (state)
      ffpa_pkg::ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) state_next = ffpa_pkg::ST_IDLE;
      end
      ffpa_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_next   = ffpa_pkg::ST_CHECK;
        end
      end
      ffpa_pkg::ST_CHECK: begin
        if (stat.op_free) begin
          if (stat.count_zero || stat.count_bad || stat.range_bad) begin
            state_next = ffpa_pkg::ST_IDLE;
          end else begin
            state_next = ffpa_pkg::ST_F_READ;
          end
        end else if (stat.count_bad) begin
          state_next = ffpa_pkg::ST_DONE_FAIL;
        end else if (stat.is_search) begin
          state_next = ffpa_pkg::ST_S_TEST;
        end else if (stat.range_bad) begin
          state_next = ffpa_pkg::ST_DONE_FAIL;
        end else begin
          state_next = ffpa_pkg::ST_MAP;
        end
      end
      // check the candidate start, then probe the next page of the run
      ffpa_pkg::ST_S_TEST: begin
        if (!stat.start_ok) begin
          state_next = ffpa_pkg::ST_DONE_FAIL;
        end else if (stat.idx_end) begin
          cmd.idx_clear = 1'b1;
          state_next    = ffpa_pkg::ST_MAP;
        end else if (stat.page_beyond) begin
          state_next = ffpa_pkg::ST_DONE_FAIL;
        end else begin
          cmd.rd_issue = 1'b1;
          state_next   = ffpa_pkg::ST_S_EVAL;
        end
      end
      ffpa_pkg::ST_S_EVAL: begin
        if (stat.page_taken) begin
          cmd.srch_skip = 1'b1;
        end else begin
          cmd.srch_adv = 1'b1;
        end
        state_next = ffpa_pkg::ST_S_TEST;
      end
      ffpa_pkg::ST_MAP: begin
        if (stat.idx_end) begin
          state_next = ffpa_pkg::ST_DONE_OK;
        end else if (stat.out_free) begin
          cmd.emit_map = 1'b1;
        end
      end
      ffpa_pkg::ST_F_READ: begin
        cmd.rd_issue = 1'b1;
        state_next   = ffpa_pkg::ST_F_EMIT;
      end
      ffpa_pkg::ST_F_EMIT: begin
        if (stat.out_free) begin
          cmd.emit_unmap = 1'b1;
          state_next     = stat.idx_last ? ffpa_pkg::ST_IDLE : ffpa_pkg::ST_F_READ;
        end
      end
      ffpa_pkg::ST_DONE_OK: begin
        if (stat.out_free) begin
          cmd.emit_done_ok = 1'b1;
          state_next       = ffpa_pkg::ST_IDLE;
        end
      end
      ffpa_pkg::ST_DONE_FAIL: begin
        if (stat.out_free) begin
          cmd.emit_done_fail = 1'b1;
          state_next         = ffpa_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = ffpa_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/core/ffpa_dpath.sv
// ffpa_dpath: request registers, page table memory, search cursor,
// configuration registers and the result register
// depends on ffpa_pkg
module ffpa_dpath (
  input  logic                                clk,
  input  logic                                rst,
  input  ffpa_pkg::ffpa_cmd_t                 cmd,
  output ffpa_pkg::ffpa_stat_t                stat,
  // request fields
  input  logic                                operation,
  input  logic [ffpa_pkg::PAGE_W-1:0]         page_index,
  input  logic [ffpa_pkg::COUNT_W-1:0]        page_count,
  input  logic [ffpa_pkg::FRAME_W-1:0]        frame_number,
  input  logic                                free_backing,
  // configuration writes
  input  logic                                cfg_we,
  input  logic [ffpa_pkg::CFG_IW-1:0]         cfg_index,
  input  logic [ffpa_pkg::LIM_W-1:0]          cfg_data,
  // result register
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [ffpa_pkg::KIND_W-1:0]         kind,
  output logic [ffpa_pkg::PAGE_W-1:0]         virtual_page,
  output logic [ffpa_pkg::FRAME_W-1:0]        frame_out,
  output logic                                release_frame,
  output logic                                success,
  output logic                                last
);

  localparam int AW  = ffpa_pkg::PAGE_AW;
  localparam int SW  = ffpa_pkg::SUM_W;
  localparam int LW  = ffpa_pkg::LIM_W;
  localparam int CW  = ffpa_pkg::COUNT_W;
  localparam int FW  = ffpa_pkg::FRAME_W;
  localparam int EW  = ffpa_pkg::ENTRY_W;

  // request and cursor registers
  logic          op_q;
  logic          search_q;
  logic          backing_q;
  logic [CW-1:0] cnt;
  logic [FW-1:0] frame_q;
  logic [LW-1:0] base;
  logic [CW-1:0] idx;

  // configuration
  logic [LW-1:0] search_first;
  logic [LW-1:0] search_end;
  logic [LW-1:0] search_stop;

  // clearing sweep
  logic [AW-1:0] clr_addr;

  // page table
  logic [EW-1:0] mem [ffpa_pkg::PAGE_LIMIT];
  logic [EW-1:0] rd_data;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [EW-1:0] wr_data;

  logic [SW-1:0] page_sum;
  logic [SW-1:0] run_end;
  logic [AW-1:0] page_addr;
  logic [FW-1:0] frame_map;
  logic          out_load;
  logic          out_free;

  assign page_sum  = SW'(base) + SW'(idx);
  assign run_end   = SW'(base) + SW'(cnt);
  assign page_addr = page_sum[AW-1:0];
  assign frame_map = frame_q + FW'(idx);
  assign search_stop = (search_end < LW'(ffpa_pkg::PAGE_LIMIT)) ?
                       search_end : LW'(ffpa_pkg::PAGE_LIMIT);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      search_first <= ffpa_pkg::SEARCH_FIRST_RST;
      search_end   <= ffpa_pkg::SEARCH_END_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ffpa_pkg::REG_SEARCH_FIRST: search_first <= cfg_data;
        ffpa_pkg::REG_SEARCH_END:   search_end   <= cfg_data;
        default: ;
      endcase
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      op_q      <= operation;
      search_q  <= (operation == ffpa_pkg::OP_ALLOC) && (page_index == '0);
      backing_q <= free_backing;
      cnt       <= page_count;
      frame_q   <= frame_number;
    end
  end

  // search cursor: start page and offset into the run
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      base <= ((operation == ffpa_pkg::OP_ALLOC) && (page_index == '0)) ?
              search_first : LW'(page_index);
    end else if (cmd.srch_skip) begin
      base <= LW'(page_sum + SW'(1));
    end
    if (cmd.load_req || cmd.idx_clear || cmd.srch_skip) begin
      idx <= '0;
    end else if (cmd.srch_adv || cmd.emit_map || cmd.emit_unmap) begin
      idx <= idx + CW'(1);
    end
  end

  // clearing sweep address
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clr_step) begin
      clr_addr <= clr_addr + AW'(1);
    end
  end

  // table write port
  always_comb begin
    wr_en   = cmd.clr_step || cmd.emit_map || cmd.emit_unmap;
    wr_addr = cmd.clr_step ? clr_addr : page_addr;
    wr_data = cmd.emit_map ? {1'b1, frame_map} : '0;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // table read port, registered
  always_ff @(posedge clk) begin
    if (cmd.rd_issue) begin
      rd_data <= mem[page_addr];
    end
  end

  // result register
  assign out_free = !out_valid || !out_stall;
  assign out_load = cmd.emit_map || cmd.emit_unmap || cmd.emit_done_ok || cmd.emit_done_fail;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (cmd.emit_map) begin
        kind          <= ffpa_pkg::KIND_MAP;
        virtual_page  <= page_sum[ffpa_pkg::PAGE_W-1:0];
        frame_out     <= frame_map;
        release_frame <= 1'b0;
        success       <= 1'b0;
        last          <= 1'b0;
      end else if (cmd.emit_unmap) begin
        kind          <= ffpa_pkg::KIND_UNMAP;
        virtual_page  <= page_sum[ffpa_pkg::PAGE_W-1:0];
        frame_out     <= (backing_q && rd_data[EW-1]) ? rd_data[FW-1:0] : '0;
        release_frame <= backing_q && rd_data[EW-1];
        success       <= 1'b0;
        last          <= (idx + CW'(1)) == cnt;
      end else if (cmd.emit_done_ok) begin
        kind          <= ffpa_pkg::KIND_DONE;
        virtual_page  <= base[ffpa_pkg::PAGE_W-1:0];
        frame_out     <= '0;
        release_frame <= 1'b0;
        success       <= 1'b1;
        last          <= 1'b1;
      end else begin
        kind          <= ffpa_pkg::KIND_DONE;
        virtual_page  <= '0;
        frame_out     <= '0;
        release_frame <= 1'b0;
        success       <= 1'b0;
        last          <= 1'b1;
      end
    end
  end

  // status to the controller
  always_comb begin
    stat.clr_last    = (clr_addr == '1);
    stat.out_free    = out_free;
    stat.op_free     = (op_q == ffpa_pkg::OP_FREE);
    stat.is_search   = search_q;
    stat.count_zero  = (cnt == '0);
    stat.count_bad   = (cnt > CW'(ffpa_pkg::MAX_RUN));
    stat.range_bad   = (run_end > SW'(ffpa_pkg::PAGE_LIMIT));
    stat.idx_end     = (idx == cnt);
    stat.idx_last    = ((idx + CW'(1)) == cnt);
    stat.start_ok    = (base < search_stop);
    stat.page_beyond = (page_sum >= SW'(ffpa_pkg::PAGE_LIMIT));
    stat.page_taken  = rd_data[EW-1];
  end

endmodule

>>> rtl/core/first_fit_page_allocator.sv
// channel  | direction | handshake             | carries
// in       | in        | in_valid / in_stall   | operation, page_index, page_count,
//          |           |                       | frame_number, free_backing
// out      | out       | out_valid / out_stall | kind, virtual_page, frame_out,
//          |           |                       | release_frame, success, last
// cfg      | in        | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// after reset a clearing pass writes all 65536 table entries, one a cycle,
// with in_stall high; configuration writes are taken during it.
// one request at a time: the idle state takes it, the check state tests it, the first-fit search
// reads and evaluates each page it probes, the map walk writes and reports each mapped page,
// the free walk reads and reports each freed page, and an alloc request ends with a done result.
// a full result register holds a walk only while out_stall is high.
//
// first_fit_page_allocator: top level, joins controller and datapath
// depends on ffpa_pkg, ffpa_ctrl, ffpa_dpath
module first_fit_page_allocator (
  input  logic                                clk,
  input  logic                                rst,
  // requests
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                operation,
  input  logic [ffpa_pkg::PAGE_W-1:0]         page_index,
  input  logic [ffpa_pkg::COUNT_W-1:0]        page_count,
  input  logic [ffpa_pkg::FRAME_W-1:0]        frame_number,
  input  logic                                free_backing,
  // results
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [ffpa_pkg::KIND_W-1:0]         kind,
  output logic [ffpa_pkg::PAGE_W-1:0]         virtual_page,
  output logic [ffpa_pkg::FRAME_W-1:0]        frame_out,
  output logic                                release_frame,
  output logic                                success,
  output logic                                last,
  // configuration
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ffpa_pkg::CFG_IW-1:0]         cfg_index,
  input  logic [ffpa_pkg::LIM_W-1:0]          cfg_data
);

  ffpa_pkg::ffpa_cmd_t  cmd;
  ffpa_pkg::ffpa_stat_t stat;

  // registers accept a write every cycle
  assign cfg_ready = 1'b1;

  ffpa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  ffpa_dpath u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .operation     (operation),
    .page_index    (page_index),
    .page_count    (page_count),
    .frame_number  (frame_number),
    .free_backing  (free_backing),
    .cfg_we        (cfg_valid && cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .kind          (kind),
    .virtual_page  (virtual_page),
    .frame_out     (frame_out),
    .release_frame (release_frame),
    .success       (success),
    .last          (last)
  );

endmodule

>>> rtl/core/ffpa_checker.sv
// ffpa_checker: port-level checks on the first-fit page allocator
// depends on ffpa_pkg; bound to first_fit_page_allocator
module ffpa_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_valid,
  input logic                                in_stall,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic [ffpa_pkg::KIND_W-1:0]         kind,
  input logic [ffpa_pkg::PAGE_W-1:0]         virtual_page,
  input logic [ffpa_pkg::FRAME_W-1:0]        frame_out,
  input logic                                release_frame,
  input logic                                success,
  input logic                                last
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(kind) && $stable(virtual_page)
      && $stable(frame_out) && $stable(last))
    else $error("stalled result changed");

  // one request at a time: no request taken right after another
  a_one_request: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("request accepted while one is in flight");

  // only unmap results return frames
  a_release_unmap: assert property (@(posedge clk) disable iff (rst)
    out_valid && release_frame |-> kind == ffpa_pkg::KIND_UNMAP)
    else $error("frame release on a non-unmap result");

  // a done result closes its request
  a_done_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == ffpa_pkg::KIND_DONE |-> last)
    else $error("done result not marked last");

  // map results never close a request and never report success
  a_map_mid: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == ffpa_pkg::KIND_MAP |-> !last && !success)
    else $error("map result marked last or successful");

endmodule

bind first_fit_page_allocator ffpa_checker u_ffpa_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .kind          (kind),
  .virtual_page  (virtual_page),
  .frame_out     (frame_out),
  .release_frame (release_frame),
  .success       (success),
  .last          (last)
);

>>> tb/tb_first_fit_page_allocator.sv
// tb_first_fit_page_allocator: self-checking testbench for first_fit_page_allocator
// predicts map, unmap and done results from a shadow page table and compares them in order
// depends on ffpa_pkg and first_fit_page_allocator
module tb_first_fit_page_allocator;
  timeunit 1ns;
  timeprecision 1ps;

  import ffpa_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 200000;
  localparam int unsigned SETTLE_CYCLES  = 64;
  localparam int unsigned PHASE_REQUESTS = 92;
  localparam int unsigned WINDOW_PAGES   = 256;

  typedef struct packed {
    logic               op;
    logic [PAGE_W-1:0]  page;
    logic [COUNT_W-1:0] count;
    logic [FRAME_W-1:0] frame;
    logic               backing;
    bit                 drain;
  } request_t;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [PAGE_W-1:0]  vpage;
    logic [FRAME_W-1:0] frame;
    logic               rel;
    logic               ok;
    logic               fin;
  } page_event_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               operation = OP_ALLOC;
  logic [PAGE_W-1:0]  page_index = '0;
  logic [COUNT_W-1:0] page_count = '0;
  logic [FRAME_W-1:0] frame_number = '0;
  logic               free_backing = 1'b0;

  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [KIND_W-1:0]  kind;
  logic [PAGE_W-1:0]  virtual_page;
  logic [FRAME_W-1:0] frame_out;
  logic               release_frame;
  logic               success;
  logic               last;

  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [CFG_IW-1:0]  cfg_index = REG_SEARCH_FIRST;
  logic [LIM_W-1:0]   cfg_data = '0;

  // shadow state of the block
  logic [ENTRY_W-1:0] shadow_table [PAGE_LIMIT];
  logic [LIM_W-1:0]   first_page_cfg = SEARCH_FIRST_RST;
  logic [LIM_W-1:0]   end_page_cfg   = SEARCH_END_RST;

  request_t    requests_todo [$];
  page_event_t events_due [$];
  request_t    cur_req;
  bit          req_taken;
  page_event_t got_event;
  page_event_t want_event;

  int unsigned sender_idle_pct = 0;
  int unsigned recv_stall_pct  = 0;
  int unsigned mismatches      = 0;
  int unsigned quiet_cycles    = 0;

  first_fit_page_allocator dut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void push_event(logic [KIND_W-1:0] k, int unsigned pg,
                                     logic [FRAME_W-1:0] fr, logic rel, logic ok, logic fin);
    page_event_t ev;
    ev.kind  = k;
    ev.vpage = PAGE_W'(pg);
    ev.frame = fr;
    ev.rel   = rel;
    ev.ok    = ok;
    ev.fin   = fin;
    events_due.push_back(ev);
  endfunction

  // a run is usable when every page exists and none is present
  function automatic bit run_is_free(int unsigned start, int unsigned cnt);
    for (int unsigned i = 0; i < cnt; i++)
      if (start + i >= PAGE_LIMIT || shadow_table[start + i][FRAME_W]) return 1'b0;
    return 1'b1;
  endfunction

  // update the shadow table for one request and queue the results it causes
  function automatic void apply_page_request(request_t rq);
    int unsigned cnt;
    int unsigned pg;
    int unsigned start;
    int unsigned stop;
    bit found;
    logic [ENTRY_W-1:0] entry;
    logic rel;
    logic [FRAME_W-1:0] fr;
    cnt = rq.count;
    pg  = rq.page;
    // free: silently dropped when empty, too long or past the table
    if (rq.op == OP_FREE) begin
      if (cnt == 0 || cnt > MAX_RUN || pg + cnt > PAGE_LIMIT) return;
      for (int unsigned i = 0; i < cnt; i++) begin
        entry = shadow_table[pg + i];
        rel = rq.backing && entry[FRAME_W];
        shadow_table[pg + i] = '0;
        push_event(KIND_UNMAP, pg + i, rel ? entry[FRAME_W-1:0] : '0, rel, 1'b0,
                   i + 1 == cnt);
      end
      return;
    end
    if (cnt > MAX_RUN) begin
      push_event(KIND_DONE, 0, '0, 1'b0, 1'b0, 1'b1);
      return;
    end
    // page 0 asks for a first-fit search
    if (pg == 0) begin
      start = first_page_cfg;
      stop  = (end_page_cfg < PAGE_LIMIT) ? end_page_cfg : PAGE_LIMIT;
      found = 1'b0;
      while (!found && start < stop) begin
        if (run_is_free(start, cnt)) found = 1'b1;
        else start++;
      end
      if (!found) begin
        push_event(KIND_DONE, 0, '0, 1'b0, 1'b0, 1'b1);
        return;
      end
      pg = start;
    end else if (pg + cnt > PAGE_LIMIT) begin
      push_event(KIND_DONE, 0, '0, 1'b0, 1'b0, 1'b1);
      return;
    end
    // map the run, frames wrap at the frame width
    for (int unsigned i = 0; i < cnt; i++) begin
      fr = rq.frame + FRAME_W'(i);
      shadow_table[pg + i] = {1'b1, fr};
      push_event(KIND_MAP, pg + i, fr, 1'b0, 1'b0, 1'b0);
    end
    push_event(KIND_DONE, pg, '0, 1'b0, 1'b1, 1'b1);
  endfunction

  function automatic void queue_request(logic op, int unsigned pg, int unsigned cnt,
                                        logic [FRAME_W-1:0] fr, logic backing);
    request_t rq;
    rq.op      = op;
    rq.page    = PAGE_W'(pg);
    rq.count   = COUNT_W'(cnt);
    rq.frame   = fr;
    rq.backing = backing;
    rq.drain   = 1'b0;
    requests_todo.push_back(rq);
  endfunction

  // mostly searches and runs inside a small window, some out-of-range noise
  function automatic request_t random_request(int unsigned base);
    request_t rq;
    int unsigned pick;
    pick = $urandom_range(99);
    rq.op      = OP_ALLOC;
    rq.page    = '0;
    rq.frame   = FRAME_W'($urandom());
    rq.backing = 1'($urandom_range(1));
    rq.drain   = 1'b0;
    if (pick < 35) begin
      rq.count = ($urandom_range(4) != 0) ? COUNT_W'($urandom_range(8, 1))
                                          : COUNT_W'($urandom_range(MAX_RUN));
    end else if (pick < 55) begin
      rq.page  = PAGE_W'(base + $urandom_range(WINDOW_PAGES - 1));
      rq.count = COUNT_W'($urandom_range(16, 1));
    end else if (pick < 85) begin
      rq.op    = OP_FREE;
      rq.page  = PAGE_W'(base + $urandom_range(WINDOW_PAGES - 1));
      rq.count = COUNT_W'($urandom_range(MAX_RUN, 1));
    end else begin
      rq.op    = 1'($urandom_range(1));
      rq.page  = PAGE_W'($urandom());
      rq.count = COUNT_W'($urandom_range(63));
    end
    return rq;
  endfunction

  // register write, only issued while the block is idle
  task automatic write_search_reg(logic [CFG_IW-1:0] idx, logic [LIM_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_SEARCH_FIRST) first_page_cfg = value;
    else end_page_cfg = value;
  endtask

  // wait for every request to go in and every result to come out
  task automatic settle();
    while (requests_todo.size() != 0 || in_valid || events_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      req_taken = in_valid && !in_stall;
      if (req_taken) apply_page_request(cur_req);
      if (!in_valid || req_taken) begin
        if (requests_todo.size() != 0 && $urandom_range(99) >= sender_idle_pct &&
            (!requests_todo[0].drain || events_due.size() == 0)) begin
          cur_req = requests_todo.pop_front();
          in_valid     <= 1'b1;
          operation    <= cur_req.op;
          page_index   <= cur_req.page;
          page_count   <= cur_req.count;
          frame_number <= cur_req.frame;
          free_backing <= cur_req.backing;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver stalls
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got_event.kind  = kind;
        got_event.vpage = virtual_page;
        got_event.frame = frame_out;
        got_event.rel   = release_frame;
        got_event.ok    = success;
        got_event.fin   = last;
        if (events_due.size() == 0) begin
          if (mismatches < 10)
            $display("%0t unexpected result kind=%0d page=%0d frame=%h rel=%b ok=%b last=%b",
                     $realtime, kind, virtual_page, frame_out, release_frame, success, last);
          mismatches++;
        end else begin
          want_event = events_due.pop_front();
          if (got_event.kind !== want_event.kind || got_event.vpage !== want_event.vpage ||
              got_event.frame !== want_event.frame || got_event.rel !== want_event.rel ||
              got_event.ok !== want_event.ok || got_event.fin !== want_event.fin) begin
            if (mismatches < 10)
              $display("%0t mismatch exp kind=%0d page=%0d frame=%h rel=%b ok=%b last=%b got kind=%0d page=%0d frame=%h rel=%b ok=%b last=%b",
                       $realtime, want_event.kind, want_event.vpage, want_event.frame,
                       want_event.rel, want_event.ok, want_event.fin, kind, virtual_page,
                       frame_out, release_frame, success, last);
            mismatches++;
          end
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("first_fit_page_allocator verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // stimulus
  initial begin
    int unsigned base;
    for (int i = 0; i < PAGE_LIMIT; i++) shadow_table[i] = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: top of table, frame wrap, overwrite, long runs, empty runs
    queue_request(OP_ALLOC, 65535, 1, 20'hFFFFF, 1'b0);
    queue_request(OP_ALLOC, 65535, 2, 20'h00001, 1'b1);
    queue_request(OP_ALLOC, 65504, 32, 20'hFFFF0, 1'b0);
    queue_request(OP_ALLOC, 0, 0, 20'h00000, 1'b0);
    queue_request(OP_ALLOC, 0, 3, 20'h00000, 1'b0);
    queue_request(OP_ALLOC, 4609, 2, 20'h12345, 1'b0);
    queue_request(OP_ALLOC, 0, 33, 20'h00100, 1'b0);
    queue_request(OP_ALLOC, 300, 63, 20'h00200, 1'b0);
    queue_request(OP_FREE, 4608, 4, 20'h00000, 1'b1);
    queue_request(OP_FREE, 65535, 1, 20'h00000, 1'b1);
    queue_request(OP_FREE, 65504, 32, 20'hFFFFF, 1'b0);
    queue_request(OP_FREE, 100, 0, 20'h00000, 1'b1);
    queue_request(OP_FREE, 100, 40, 20'h00000, 1'b1);
    queue_request(OP_FREE, 65535, 2, 20'h00000, 1'b1);
    queue_request(OP_ALLOC, 1, 32, 20'h00000, 1'b0);
    queue_request(OP_FREE, 0, 32, 20'h00000, 1'b1);
    settle();

    // search from page 0 may land on base 0
    write_search_reg(REG_SEARCH_FIRST, 0);
    queue_request(OP_ALLOC, 0, 1, 20'hABCDE, 1'b0);
    queue_request(OP_ALLOC, 0, 2, 20'h54321, 1'b0);
    settle();

    // search near the end of the table, runs past it count as taken
    write_search_reg(REG_SEARCH_FIRST, 65530);
    queue_request(OP_ALLOC, 0, 10, 20'h00010, 1'b0);
    queue_request(OP_ALLOC, 0, 6, 20'h00020, 1'b0);
    settle();

    // no start positions at all
    write_search_reg(REG_SEARCH_FIRST, 65536);
    queue_request(OP_ALLOC, 0, 1, 20'h00030, 1'b0);
    settle();
    write_search_reg(REG_SEARCH_FIRST, 100);
    write_search_reg(REG_SEARCH_END, 0);
    queue_request(OP_ALLOC, 0, 0, 20'h00040, 1'b0);
    settle();

    // random phases, each with its own search window and idling pattern
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          base = 4608;
          write_search_reg(REG_SEARCH_FIRST, 4608);
          write_search_reg(REG_SEARCH_END, 65536);
          sender_idle_pct = 0;
          recv_stall_pct  = 0;
        end
        1: begin
          base = 0;
          write_search_reg(REG_SEARCH_FIRST, 0);
          write_search_reg(REG_SEARCH_END, 300);
          sender_idle_pct = 61;
          recv_stall_pct  = 0;
        end
        2: begin
          base = 40000;
          write_search_reg(REG_SEARCH_FIRST, 40000);
          write_search_reg(REG_SEARCH_END, 40100);
          sender_idle_pct = 0;
          recv_stall_pct  = 61;
        end
        default: begin
          base = 65200;
          write_search_reg(REG_SEARCH_FIRST, 65200);
          write_search_reg(REG_SEARCH_END, 65536);
          sender_idle_pct = 34;
          recv_stall_pct  = 34;
        end
      endcase
      for (int unsigned n = 0; n < PHASE_REQUESTS; n++) begin
        requests_todo.push_back(random_request(base));
        // hold the sender once per phase until the block has drained
        if (n == PHASE_REQUESTS / 2) requests_todo[requests_todo.size() - 1].drain = 1'b1;
      end
      settle();
    end

    mismatches += events_due.size();
    if (mismatches == 0) begin
      $display("first_fit_page_allocator verification clean");
    end else begin
      $display("first_fit_page_allocator verification failed");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/ffpa_pkg.sv
rtl/core/ffpa_ctrl.sv
rtl/core/ffpa_dpath.sv
rtl/core/first_fit_page_allocator.sv
rtl/core/ffpa_checker.sv
tb/tb_first_fit_page_allocator.sv
